// ===== src/match_pwm_timer_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MATCH_PWM_TIMER_CORE_ASSERT_SVH
`define MATCH_PWM_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mpt_pkg.sv =====
package mpt_pkg;

  localparam int CHANNELS = 6;
  localparam int COUNT_W = 32;
  localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncWrite = 2'd1,
    FuncClear = 2'd2
  } mpt_func_e;

  typedef enum logic [2:0] {
    RegPrescale  = 3'd0,
    RegPeriod    = 3'd1,
    RegDblMask   = 3'd2,
    RegOutEnable = 3'd3,
    RegIrqEnable = 3'd4,
    RegCntEnable = 3'd5
  } mpt_reg_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  channel_select;
    logic [31:0] match_value;
    logic        latch_request;
  } mpt_in_t;

  typedef struct packed {
    logic [5:0]  pwm_out;
    logic [31:0] count_value;
    logic        period_wrap;
    logic        irq_pending;
  } mpt_out_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  prescale;
    logic [COUNT_W-1:0]  period;
    logic [CHANNELS-1:0] double_edge_mask;
    logic [CHANNELS-1:0] output_enable_mask;
    logic                irq_enable;
    logic                counter_enable;
  } mpt_cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                prescale_count;
    logic [COUNT_W-1:0]                timer_count;
    logic [CHANNELS-1:0][COUNT_W-1:0]  match_shadow;
    logic [CHANNELS-1:0][COUNT_W-1:0]  match_active;
    logic [CHANNELS-1:0]               latch_pending;
    logic [CHANNELS-1:0]               output_level;
    logic                              irq_flag;
  } mpt_state_t;

endpackage

// ===== src/mpt_step.sv =====
module mpt_step (
  input  mpt_pkg::mpt_state_t state_i,
  input  mpt_pkg::mpt_cfg_t   cfg_i,
  input  mpt_pkg::mpt_in_t    item_i,
  output mpt_pkg::mpt_state_t state_o,
  output mpt_pkg::mpt_out_t   result_o
);
  import mpt_pkg::*;

  logic [CHAN_IDX_W-1:0] ch_idx;
  logic                  ch_ok;
  logic                  step;
  logic                  wrap;
  logic [CHANNELS-1:0]   fired;
  logic [CHANNELS-1:0]   dbl;
  logic [CHANNELS-1:0]   set;

  assign ch_idx = CHAN_IDX_W'(item_i.channel_select - 3'd1);
  assign ch_ok  = (item_i.channel_select >= 3'd1) &&
                  (item_i.channel_select <= 3'(CHANNELS));
  // Channel one has no predecessor, so it is always single edge.
  assign dbl    = cfg_i.double_edge_mask & ~CHANNELS'(1);

  always_comb begin
    state_o = state_i;
    step    = 1'b0;
    wrap    = 1'b0;
    fired   = '0;
    set     = '0;

    case (item_i.func)
      FuncTick: begin
        if (cfg_i.counter_enable) begin
          if (state_i.prescale_count >= cfg_i.prescale) begin
            state_o.prescale_count = '0;
            step = 1'b1;
          end else begin
            state_o.prescale_count = state_i.prescale_count + 1'b1;
          end
        end
      end
      FuncWrite: begin
        if (ch_ok) begin
          state_o.match_shadow[ch_idx] = item_i.match_value;
          if (item_i.latch_request) begin
            state_o.latch_pending[ch_idx] = 1'b1;
          end
        end
      end
      FuncClear: begin
        state_o.irq_flag = 1'b0;
      end
      default: begin
      end
    endcase

    if (step) begin
      if ((state_i.timer_count >= cfg_i.period) || (&state_i.timer_count)) begin
        wrap = 1'b1;
        state_o.timer_count = '0;
        // Load latched shadows at the wrap.
        for (int n = 0; n < CHANNELS; n++) begin
          if (state_i.latch_pending[n]) begin
            state_o.match_active[n] = state_i.match_shadow[n];
          end
        end
        state_o.latch_pending = '0;
        if (cfg_i.irq_enable) begin
          state_o.irq_flag = 1'b1;
        end
      end else begin
        state_o.timer_count = state_i.timer_count + 1'b1;
      end

      for (int n = 0; n < CHANNELS; n++) begin
        fired[n] = (state_o.match_active[n] == state_o.timer_count) &&
                   (state_o.match_active[n] <= cfg_i.period);
      end

      set = (dbl & (fired << 1)) | (~dbl & {CHANNELS{wrap}});
      // Clear wins over set on the same step.
      state_o.output_level = (state_i.output_level | set) & ~fired;
    end

    result_o.pwm_out     = 6'(state_o.output_level & cfg_i.output_enable_mask);
    result_o.count_value = 32'(state_o.timer_count);
    result_o.period_wrap = wrap;
    result_o.irq_pending = state_o.irq_flag;
  end

endmodule

// ===== src/match_pwm_timer_core.sv =====
// Six-channel match PWM timer.
// Input channel (in_valid_i / in_stall_o / in_data_i): each beat is a tick, a
// shadow match write (with optional latch at the next wrap) or an interrupt
// clear. Every input beat yields exactly one output beat (out_valid_o /
// out_stall_i / out_data_o) with the enabled PWM levels, the counter value,
// the wrap flag and the interrupt flag after that beat.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
// is always ready; write it only while no beat is in flight.
// Throughput: one beat per cycle while the receiver does not stall; each item
// passes the input register, one combinational step through the next-state
// logic, and the result register, from which the result is offered.
// When the receiver stalls, the result register holds its beat, the input
// register takes one more beat, then in_stall_o rises until the result moves.
// Reset clears configuration, prescaler, counter, match registers, latch
// flags, output levels and the interrupt flag, and empties both registers.
module match_pwm_timer_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mpt_pkg::mpt_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mpt_pkg::mpt_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import mpt_pkg::*;

  mpt_cfg_t   cfg_q, cfg_d;
  mpt_state_t state_q, state_d;
  mpt_in_t    in_q;
  logic       in_valid_q, in_valid_d;
  mpt_out_t   out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       out_load;
  logic       in_take;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPrescale:  cfg_d.prescale           = COUNT_W'(cfg_data_i);
        RegPeriod:    cfg_d.period             = COUNT_W'(cfg_data_i);
        RegDblMask:   cfg_d.double_edge_mask   = cfg_data_i[CHANNELS-1:0];
        RegOutEnable: cfg_d.output_enable_mask = cfg_data_i[CHANNELS-1:0];
        RegIrqEnable: cfg_d.irq_enable         = cfg_data_i[0];
        RegCntEnable: cfg_d.counter_enable     = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  mpt_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: hold unless a beat moves in.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== src/mpt_checker.sv =====
`include "match_pwm_timer_core_assert.svh"

module mpt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input mpt_pkg::mpt_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mpt_pkg::mpt_out_t out_data_o
);
  import mpt_pkg::*;

  logic in_seen;

  assign in_seen = in_valid_i && (in_data_i.func != FuncWrite || !in_data_i.latch_request ||
                   in_data_i.channel_select != 3'd0);

  // Input backs up only behind a held result.
  `MPT_ASSERT_NOW(a_stall_needs_full, in_stall_o, out_valid_o && out_stall_i,
    "input stalled while result register can move")

  // A wrap always leaves the counter at zero.
  `MPT_ASSERT_NOW(a_wrap_zero, out_valid_o && out_data_o.period_wrap,
    out_data_o.count_value == 32'd0, "wrap reported with nonzero count")

  `MPT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed")

  // A beat accepted while no result is offered passes both registers and reaches the output.
  `MPT_ASSERT_NEXT(a_empty_pass, in_seen && !in_stall_o && !out_valid_o,
    ##1 out_valid_o, "accepted beat never reached the output")

endmodule

bind match_pwm_timer_core mpt_checker u_mpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
